### rtl/bse_pkg.sv
// Shared constants and types for the bubble sort engine.
// No dependencies; imported by the controller, the top level and the bench.
`timescale 1ns / 1ps
`default_nettype none

package bse_pkg;

  localparam int MaxItems = 32;
  localparam int DataW    = 32;
  localparam int AddrW    = $clog2(MaxItems);
  localparam int CntW     = $clog2(MaxItems + 1);

  typedef enum logic [1:0] {
    StLoad,
    StSort,
    StFlush,
    StOut
  } state_e;

  // One write port and one read port of the value store
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### rtl/bse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bse_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/bse_ctrl.sv
// Sequencer of the bubble sort engine: load, sort passes over the store, readout.
// Depends on bse_pkg; drives the value store RAM through a mem_req_t.
`timescale 1ns / 1ps
`default_nettype none

module bse_ctrl
  import bse_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [DataW-1:0] value_in_i,
  input  wire logic             last_in_i,
  output mem_req_t              mem_req_o,
  input  wire logic [DataW-1:0] mem_rdata_i,
  output logic                  result_valid_o,
  output logic                  last_out_o
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  pass_q, pass_d;
  logic [DataW-1:0] carry_q, carry_d;
  logic             out_vld_q, out_vld_d;
  logic             out_last_q, out_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      cnt_q      <= '0;
      k_q        <= '0;
      pass_q     <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      k_q        <= k_d;
      pass_q     <= pass_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  always_comb begin
    logic [CntW-1:0] wr_idx;
    logic [CntW-1:0] top_idx;
    logic            swap;
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    pass_d     = pass_q;
    carry_d    = carry_q;
    out_vld_d  = 1'b0;
    out_last_d = 1'b0;
    wr_idx     = k_q - CntW'(2);
    top_idx    = cnt_q - CntW'(1);
    swap       = $signed(mem_rdata_i) < $signed(carry_q);
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = '0;
    mem_req_o.wdata = carry_q;
    mem_req_o.raddr = k_q[AddrW-1:0];

    case (state_q)
      StLoad: begin
        if (start) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cnt_q[AddrW-1:0];
          mem_req_o.wdata = value_in_i;
          cnt_d           = cnt_q + CntW'(1);
          if (last_in_i || cnt_q == CntW'(MaxItems - 1)) begin
            k_d     = '0;
            pass_d  = '0;
            state_d = (cnt_q == '0) ? StOut : StSort;
          end
        end
      end

      // Stream reads 0..n-1; the largest value seen so far rides in carry_q
      StSort: begin
        if (k_q == CntW'(1)) begin
          carry_d = mem_rdata_i;
        end else if (k_q != '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = wr_idx[AddrW-1:0];
          mem_req_o.wdata = swap ? mem_rdata_i : carry_q;
          carry_d         = swap ? carry_q : mem_rdata_i;
        end
        if (k_q == cnt_q) begin
          k_d     = '0;
          state_d = StFlush;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end

      // Drop the carried maximum into the top entry, then next pass or readout
      StFlush: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = top_idx[AddrW-1:0];
        mem_req_o.wdata = carry_q;
        k_d             = '0;
        if (pass_q == cnt_q - CntW'(2)) begin
          pass_d  = '0;
          state_d = StOut;
        end else begin
          pass_d  = pass_q + CntW'(1);
          state_d = StSort;
        end
      end

      StOut: begin
        out_vld_d  = 1'b1;
        out_last_d = (k_q == top_idx);
        if (k_q == top_idx) begin
          k_d     = '0;
          cnt_d   = '0;
          state_d = StLoad;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end

      default: begin
        state_d = StLoad;
      end
    endcase
  end

  assign busy           = (state_q != StLoad);
  assign result_valid_o = out_vld_q;
  assign last_out_o     = out_last_q;

endmodule

`default_nettype wire

### rtl/bubble_sort_engine_unit.sv
// Top level of the bubble sort engine: controller plus the value store RAM.
// Depends on bse_pkg, bse_ctrl and bse_ram.
//
// Usage:
//   Input: an item (value_in_i, last_in_i) is taken at a rising edge where
//   start is high and busy is low. last_in_i ends the set; the item that
//   fills the store (MaxItems values) also ends it.
//   Sort: n-1 passes over the store for a set of n values (none for n = 1).
//   Each pass streams the store through the single read port of the RAM
//   and writes back one entry per cycle, one entry behind the read.
//   Output: n results, one per cycle, each marked by result_valid_o for one
//   cycle; last_out_o marks the largest value. The receiver cannot stall
//   the results.
//   busy stays high from the item that ends the set until the cycle of the
//   final result, where a new set may start loading.
//   Reset: the block returns to loading with an empty set; store contents
//   are not cleared, and no stale entry ever reaches a valid result.
`timescale 1ns / 1ps
`default_nettype none

module bubble_sort_engine_unit
  import bse_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [DataW-1:0] value_in_i,
  input  wire logic             last_in_i,
  output logic                  result_valid_o,
  output logic [DataW-1:0]      value_out_o,
  output logic                  last_out_o
);

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;

  bse_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_in_i     (value_in_i),
    .last_in_i      (last_in_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .last_out_o     (last_out_o)
  );

  bse_ram #(
    .Width (DataW),
    .Depth (MaxItems)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign value_out_o = mem_rdata;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for bubble_sort_engine_unit: loads sets of values and
// checks the emitted ascending stream. Depends on bse_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;
  import bse_pkg::*;

  localparam int unsigned RunItems   = 200;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    logic [DataW-1:0] value;
    logic             last;
  } sorted_entry_t;

  // Collects the current set, orders it on its closing item and queues the
  // ascending values that the engine must emit.
  class sort_checker;
    logic signed [DataW-1:0] set_buf [$];
    int unsigned             set_len;
    sorted_entry_t           sorted_q [$];
    int unsigned             n_bad, n_results, n_sets, n_filled;

    function void take_item(logic [DataW-1:0] v, logic l);
      logic signed [DataW-1:0] tmp;
      int unsigned             p, k;
      sorted_entry_t           e;
      set_buf.push_back(v);
      set_len++;
      if (!l && set_len < MaxItems) return;
      // a full store closes the set even without the end flag
      if (!l) n_filled++;
      n_sets++;
      for (p = 0; p + 1 < set_len; p++) begin
        for (k = 1; k < set_len; k++) begin
          if (set_buf[k] < set_buf[k-1]) begin
            tmp          = set_buf[k];
            set_buf[k]   = set_buf[k-1];
            set_buf[k-1] = tmp;
          end
        end
      end
      for (k = 0; k < set_len; k++) begin
        e.value = set_buf[k];
        e.last  = (k + 1 == set_len);
        sorted_q.push_back(e);
      end
      set_buf.delete();
      set_len = 0;
    endfunction

    function void check_result(logic [DataW-1:0] v, logic l);
      sorted_entry_t e;
      n_results++;
      if (sorted_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] unexpected result value=%h last=%b", $realtime, v, l);
        return;
      end
      e = sorted_q.pop_front();
      if (v !== e.value) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] value_out mismatch: exp %h got %h", $realtime, e.value, v);
      end
      if (l !== e.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display("[%0t] last_out mismatch: exp %b got %b", $realtime, e.last, l);
      end
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction

    // leftover expectations and an unfinished set both count as failures
    function int unsigned close_out();
      if (sorted_q.size() != 0)
        $display("%0d results never arrived", sorted_q.size());
      return n_bad + sorted_q.size() + (set_len != 0);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [DataW-1:0] value_in;
  logic             last_in;
  logic             result_valid;
  logic [DataW-1:0] value_out;
  logic             last_out;

  sort_checker chk;
  int unsigned items_sent;

  bubble_sort_engine_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_in_i     (value_in),
    .last_in_i      (last_in),
    .result_valid_o (result_valid),
    .value_out_o    (value_out),
    .last_out_o     (last_out)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Results are checked before the item of the same edge is noted, since a
  // new set may load in the cycle of the previous set's final result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid) chk.check_result(value_out, last_out);
      if (start && !busy) chk.take_item(value_in, last_in);
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    for (cyc = 0; cyc < CycleLimit; cyc++) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one item, hold it until accepted, then idle for a random gap, which may be zero.
  task automatic drive_item(input logic [DataW-1:0] v, input logic l, input bit calm);
    int unsigned r, gap;
    @(negedge clk_i);
    start    <= 1'b1;
    value_in <= v;
    last_in  <= l;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    r   = $urandom_range(0, 99);
    gap = (calm || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      start    <= 1'b0;
      value_in <= $urandom();
      last_in  <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Hold off the sender until every queued result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (chk.pending() != 0) @(negedge clk_i);
  endtask

  logic [DataW-1:0] dir_vals [20] = '{
    32'h8000_0000,
    32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0005,
    32'h8000_0001, 32'hFFFF_FFFE, 32'h0000_0002, 32'h7FFF_FFFE,
    32'h7FFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFE, 32'h8000_0001,
    32'h7FFF_FFFF
  };
  bit dir_last [20] = '{1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1,
                        0, 0, 0, 1, 0, 0, 0, 1, 1};

  initial begin : stimulus
    int unsigned i, set_size, mode, r, fails;
    bit          calm, end_flag, first_random;
    logic [DataW-1:0] v;

    chk        = new();
    items_sent = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    value_in   = '0;
    last_in    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // single values, extremes, duplicates, sorted and reversed sets
    for (i = 0; i < 20; i++) drive_item(dir_vals[i[4:0]], dir_last[i[4:0]], i[0]);
    drain_results();

    first_random = 1'b1;
    while (items_sent < RunItems) begin
      r = $urandom_range(0, 99);
      if (first_random || r < 8) set_size = MaxItems;
      else if (r < 60)           set_size = $urandom_range(1, 6);
      else                       set_size = $urandom_range(7, 16);
      // a full set usually carries no end flag on its final item
      end_flag = (set_size < MaxItems) || ($urandom_range(0, 3) == 0 && !first_random);
      first_random = 1'b0;
      mode = $urandom_range(0, 2);
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < set_size; i++) begin
        case (mode)
          0: v = $urandom();
          1: v = $urandom_range(0, 6) - 3;
          default: begin
            r = $urandom_range(0, 4);
            v = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
                (r == 2) ? 32'hFFFF_FFFF : (r == 3) ? 32'h0000_0000 : $urandom();
          end
        endcase
        drive_item(v, (i + 1 == set_size) ? end_flag : 1'b0, calm);
      end
      if ($urandom_range(0, 6) == 0) drain_results();
    end

    drain_results();
    repeat (40) @(negedge clk_i);

    fails = chk.close_out();
    $display("Sent %0d items in %0d sets (%0d closed by a full store), checked %0d results.",
             items_sent, chk.n_sets, chk.n_filled, chk.n_results);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fails);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### bubble_sort_engine_unit.f
rtl/bse_pkg.sv
rtl/bse_ram.sv
rtl/bse_ctrl.sv
rtl/bubble_sort_engine_unit.sv
verif/tb_top.sv
